// File: rtl/audio_clock_drift_lock_loop_unit_assert.svh
// assertion macros used by the drift lock loop checker
`ifndef AUDIO_CLOCK_DRIFT_LOCK_LOOP_UNIT_ASSERT_SVH
`define AUDIO_CLOCK_DRIFT_LOCK_LOOP_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during rst
`define ACDL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, quiet during rst
`define ACDL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/acdl_pkg.sv
// types and constants of the audio clock drift lock loop
`default_nettype none

package acdl_pkg;

  // loop modes, as reported on mode_out
  typedef enum logic [1:0] {
    MODE_INIT   = 2'd0,
    MODE_CALIB  = 2'd1,
    MODE_OFFSET = 2'd2,
    MODE_LOCKED = 2'd3
  } mode_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_START,
    ST_DIV,
    ST_APPLY,
    ST_EMIT
  } state_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEVEL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_FREQ   = 1'd1;

  // register reset values
  localparam logic [7:0]  TARGET_RESET = 8'd2;
  localparam logic [15:0] START_RESET  = 16'd39846;

  // PLL word limits
  localparam logic [15:0] WORD_MIN    = 16'h8FD8;
  localparam logic [15:0] WORD_CENTRE = 16'h9BA6;
  localparam logic [15:0] WORD_MAX    = 16'hA774;

  // word step limit and error thresholds (microseconds)
  localparam logic [16:0] ADJ_MAX       = 17'd24;
  localparam logic [11:0] LOCK_THRESH   = 12'd16;
  localparam logic [11:0] UNLOCK_THRESH = 12'd32;
  localparam logic [1:0]  UNLOCK_LIMIT  = 2'd3;
  localparam logic [3:0]  OFFSET_LIMIT  = 4'd10;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic capture;
    logic push;
    logic div_start;
    logic apply;
    logic emit;
  } acdl_ctl_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic  reset_path;
    mode_t mode;
    logic  calib_last;
    logic  div_done;
  } acdl_sts_t;

  // limit a non-negative word to the PLL range
  function automatic logic [15:0] clamp_word(input logic [16:0] v);
    logic [15:0] w;
    if (v < {1'b0, WORD_MIN}) begin
      w = WORD_MIN;
    end else if (v > {1'b0, WORD_MAX}) begin
      w = WORD_MAX;
    end else begin
      w = v[15:0];
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// File: rtl/audio_clock_drift_lock_loop_unit.sv
// top level of the audio clock drift lock loop
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------------
//   in      | sink      | in_valid / in_ready    | cmd, fill_level
//   out     | source    | out_valid / out_ready  | freq_out, freq_written, locked,
//           |           |                        | mode_out, error_out
//   cfg     | sink      | cfg_valid / cfg_ready  | cfg_index, cfg_value
//
// restart items and init or mid-calibration samples: accept, push, then emit
// closing calibration sample: push, start, apply, emit (reciprocal multiply, no divide)
// offset and locked samples: push, start, divide, apply, emit, as the divider yields
// one quotient bit per cycle of the 10-bit average sum at the default parameters
// the next item is taken in the cycle after a result is emitted
// reset clears the control state; cfg_ready is always high; a result left
// waiting holds emission of the next one, and no new item is accepted meanwhile
`default_nettype none

module audio_clock_drift_lock_loop_unit
  import acdl_pkg::*;
#(
  parameter int CALIB_SAMPLES = 10,
  parameter int AVG_DEPTH     = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 cmd,
  input  logic [7:0]           fill_level,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [15:0]          freq_out,
  output logic                 freq_written,
  output logic                 locked,
  output logic [1:0]           mode_out,
  output logic signed [11:0]   error_out,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_value
);

  acdl_ctl_t ctl;
  acdl_sts_t sts;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  acdl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  acdl_datapath #(
    .CALIB_SAMPLES (CALIB_SAMPLES),
    .AVG_DEPTH     (AVG_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .cmd          (cmd),
    .fill_level   (fill_level),
    .cfg_wr       (cfg_valid & cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_value    (cfg_value),
    .freq_out     (freq_out),
    .freq_written (freq_written),
    .locked       (locked),
    .mode_out     (mode_out),
    .error_out    (error_out)
  );

endmodule

`default_nettype wire

// File: rtl/acdl_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module acdl_div #(
  parameter int NW  = 15,
  parameter int DVW = 7
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [NW-1:0]  dividend,
  input  logic [DVW-1:0] divisor,
  output logic [NW-1:0]  quotient,
  output logic           done
);

  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DVW:0]  rem;
  logic [NW-1:0] quo;
  logic [DVW-1:0] dsr;
  logic [DVW:0]  shifted;
  logic          ge;

  // trial subtract of the next partial remainder
  assign shifted = {rem[DVW-1:0], quo[NW-1]};
  assign ge      = shifted >= {1'b0, dsr};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(NW - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? (shifted - {1'b0, dsr}) : shifted;
      quo <= {quo[NW-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

// File: rtl/acdl_ctrl.sv
// sequencer of the drift lock loop: handshakes and datapath commands
`default_nettype none

module acdl_ctrl
  import acdl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output acdl_ctl_t ctl,
  input  acdl_sts_t sts
);

  state_t state;
  state_t state_next;

  // state and result valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (sts.reset_path) begin
          state_next = ST_EMIT;
        end else begin
          case (sts.mode)
            MODE_INIT:  state_next = ST_EMIT;
            MODE_CALIB: state_next = sts.calib_last ? ST_START : ST_EMIT;
            default:    state_next = ST_START;
          endcase
        end
      end
      ST_START: state_next = (sts.mode == MODE_CALIB) ? ST_APPLY : ST_DIV;
      ST_DIV: begin
        if (sts.div_done) state_next = ST_APPLY;
      end
      ST_APPLY: state_next = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    in_ready      = (state == ST_IDLE);
    ctl.capture   = (state == ST_IDLE) && in_valid;
    ctl.push      = (state == ST_PUSH);
    ctl.div_start = (state == ST_START) && (sts.mode != MODE_CALIB);
    ctl.apply     = (state == ST_APPLY);
    ctl.emit      = (state == ST_EMIT) && (!out_valid || out_ready);
  end

endmodule

`default_nettype wire

// File: rtl/acdl_datapath.sv
// datapath of the drift lock loop: averages, error, word and mode state
`default_nettype none

module acdl_datapath
  import acdl_pkg::*;
#(
  parameter int CALIB_SAMPLES = 10,
  parameter int AVG_DEPTH     = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  acdl_ctl_t            ctl,
  output acdl_sts_t            sts,
  input  logic                 cmd,
  input  logic [7:0]           fill_level,
  input  logic                 cfg_wr,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_value,
  output logic [15:0]          freq_out,
  output logic                 freq_written,
  output logic                 locked,
  output logic [1:0]           mode_out,
  output logic signed [11:0]   error_out
);

  localparam int CS_W = $clog2(255 * CALIB_SAMPLES + 1);
  localparam int CC_W = $clog2(CALIB_SAMPLES + 1);
  localparam int AS_W = $clog2(255 * AVG_DEPTH + 1);
  localparam int FL_W = $clog2(AVG_DEPTH + 1);
  localparam int IX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int NW   = AS_W;
  localparam int DVW  = FL_W;

  // reciprocal of the calibration window, exact floor for every reachable sum
  localparam int RC_L = $clog2(CALIB_SAMPLES);
  localparam int RC_S = CS_W + RC_L;
  localparam int RC_M = ((2 ** RC_S) + CALIB_SAMPLES - 1) / CALIB_SAMPLES;
  localparam int RP_W = 2 * CS_W + 1;

  // configuration registers
  logic [7:0]  target_level;
  logic [15:0] start_freq;

  // captured item
  logic       cmd_q;
  logic [7:0] level_q;

  // loop state
  mode_t       mode, mode_next;
  logic        reset_pending, reset_pending_next;
  logic [15:0] current_freq, current_freq_next;
  logic [15:0] centre_freq, centre_freq_next;
  logic [7:0]  avg_win [AVG_DEPTH];
  logic [AS_W-1:0] avg_sum, avg_sum_next;
  logic [IX_W-1:0] avg_idx, avg_idx_next;
  logic [FL_W-1:0] avg_fill, avg_fill_next;
  logic [CS_W-1:0] calib_sum, calib_sum_next;
  logic [CC_W-1:0] calib_count, calib_count_next;
  logic [1:0]  unlock_strikes, unlock_strikes_next;
  logic [3:0]  offset_tries, offset_tries_next;
  logic        res_written, res_written_next;
  logic signed [11:0] res_err, res_err_next;

  // divider operands and error path
  logic [NW-1:0]  div_dividend;
  logic [DVW-1:0] div_divisor;
  logic [NW-1:0]  div_quotient;
  logic           div_done;
  logic [RP_W-1:0] calib_prod;
  logic [7:0]  calib_avg;
  logic [7:0]  fill_avg;
  logic signed [9:0]  diff;
  logic signed [11:0] diff_w;
  logic signed [11:0] err_c;
  logic [11:0] err_abs;
  logic [16:0] base_w;
  logic [16:0] word_raw;
  logic [15:0] word;
  logic [1:0]  strikes_inc;
  logic [3:0]  tries_inc;

  assign sts.reset_path = reset_pending | cmd_q;
  assign sts.mode       = mode;
  assign sts.calib_last = (calib_count == CC_W'(CALIB_SAMPLES - 1));
  assign sts.div_done   = div_done;

  // the divider takes the moving average over its current fill
  assign div_dividend = avg_sum;
  assign div_divisor  = avg_fill;

  acdl_div #(
    .NW  (NW),
    .DVW (DVW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  // calibration mean by reciprocal multiplication
  assign calib_prod = RP_W'(calib_sum) * RP_W'(RC_M);
  assign fill_avg   = (mode == MODE_CALIB) ? calib_avg : div_quotient[7:0];

  // error: (target - level) * 10 / 2, exactly five times the difference, zero within +-1
  assign diff    = $signed({2'b00, target_level}) - $signed({2'b00, fill_avg});
  assign diff_w  = {{2{diff[9]}}, diff};
  assign err_c   = (diff >= -10'sd1 && diff <= 10'sd1) ? 12'sd0 : (diff_w <<< 2) + diff_w;
  assign err_abs = err_c[11] ? 12'(-err_c) : 12'(err_c);

  // word step: any error outside the deadband (at least 10 us) moves
  // the word by the full step limit, whatever its size
  assign base_w = {1'b0, (mode == MODE_CALIB) ? WORD_CENTRE : centre_freq};
  always_comb begin
    if (err_c > 12'sd0) begin
      word_raw = base_w - ADJ_MAX;
    end else if (err_c < 12'sd0) begin
      word_raw = base_w + ADJ_MAX;
    end else begin
      word_raw = base_w;
    end
  end
  assign word = clamp_word(word_raw);

  assign strikes_inc = unlock_strikes + 2'd1;
  assign tries_inc   = offset_tries + 4'd1;

  // next loop state
  always_comb begin
    logic  enter_en;
    mode_t enter_mode;
    enter_en            = 1'b0;
    enter_mode          = MODE_INIT;
    mode_next           = mode;
    reset_pending_next  = reset_pending;
    current_freq_next   = current_freq;
    centre_freq_next    = centre_freq;
    avg_sum_next        = avg_sum;
    avg_idx_next        = avg_idx;
    avg_fill_next       = avg_fill;
    calib_sum_next      = calib_sum;
    calib_count_next    = calib_count;
    unlock_strikes_next = unlock_strikes;
    offset_tries_next   = offset_tries;
    res_written_next    = res_written;
    res_err_next        = res_err;

    // first step of an item: reset handling, average and calibration sums
    if (ctl.push) begin
      res_written_next = 1'b0;
      res_err_next     = '0;
      if (reset_pending || cmd_q) begin
        if (reset_pending) current_freq_next = clamp_word({1'b0, start_freq});
        reset_pending_next = 1'b0;
        centre_freq_next   = WORD_CENTRE;
        enter_en           = 1'b1;
        enter_mode         = MODE_INIT;
      end else begin
        if (avg_fill < FL_W'(AVG_DEPTH)) begin
          avg_fill_next = avg_fill + 1'b1;
          avg_sum_next  = avg_sum + AS_W'(level_q);
        end else begin
          avg_sum_next = avg_sum - AS_W'(avg_win[avg_idx]) + AS_W'(level_q);
        end
        avg_idx_next = (avg_idx == IX_W'(AVG_DEPTH - 1)) ? '0 : avg_idx + 1'b1;
        case (mode)
          MODE_INIT: begin
            enter_en   = 1'b1;
            enter_mode = MODE_CALIB;
          end
          MODE_CALIB: begin
            calib_sum_next   = calib_sum + CS_W'(level_q);
            calib_count_next = calib_count + 1'b1;
          end
          default: ;
        endcase
      end
    end

    // second step: word update and mode decisions from the averaged fill
    if (ctl.apply) begin
      case (mode)
        MODE_CALIB: begin
          // calibrated centre always lies inside the word range
          centre_freq_next  = word;
          current_freq_next = word;
          res_written_next  = (word != current_freq);
          enter_en          = 1'b1;
          enter_mode        = MODE_OFFSET;
        end
        MODE_OFFSET: begin
          res_err_next      = err_c;
          current_freq_next = word;
          res_written_next  = (word != current_freq);
          if (err_abs < LOCK_THRESH) begin
            enter_en   = 1'b1;
            enter_mode = MODE_LOCKED;
          end else begin
            offset_tries_next = tries_inc;
            if (tries_inc >= OFFSET_LIMIT) begin
              enter_en   = 1'b1;
              enter_mode = MODE_INIT;
            end
          end
        end
        MODE_LOCKED: begin
          res_err_next      = err_c;
          current_freq_next = word;
          res_written_next  = (word != current_freq);
          if (err_abs > UNLOCK_THRESH) begin
            unlock_strikes_next = strikes_inc;
            if (strikes_inc >= UNLOCK_LIMIT) begin
              enter_en   = 1'b1;
              enter_mode = MODE_OFFSET;
            end
          end else begin
            unlock_strikes_next = '0;
          end
        end
        default: ;
      endcase
    end

    // mode entry clears average, strikes, tries; calib sums too into init or calibrate
    if (enter_en) begin
      mode_next           = enter_mode;
      avg_sum_next        = '0;
      avg_idx_next        = '0;
      avg_fill_next       = '0;
      unlock_strikes_next = '0;
      offset_tries_next   = '0;
      if (enter_mode == MODE_INIT || enter_mode == MODE_CALIB) begin
        calib_sum_next   = '0;
        calib_count_next = '0;
      end
    end
  end

  // control state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_level   <= TARGET_RESET;
      start_freq     <= START_RESET;
      mode           <= MODE_INIT;
      reset_pending  <= 1'b1;
      current_freq   <= START_RESET;
      centre_freq    <= WORD_CENTRE;
      avg_sum        <= '0;
      avg_idx        <= '0;
      avg_fill       <= '0;
      calib_sum      <= '0;
      calib_count    <= '0;
      unlock_strikes <= '0;
      offset_tries   <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          REG_TARGET_LEVEL: target_level <= cfg_value[7:0];
          REG_START_FREQ:   start_freq   <= cfg_value;
          default: ;
        endcase
      end
      mode           <= mode_next;
      reset_pending  <= reset_pending_next;
      current_freq   <= current_freq_next;
      centre_freq    <= centre_freq_next;
      avg_sum        <= avg_sum_next;
      avg_idx        <= avg_idx_next;
      avg_fill       <= avg_fill_next;
      calib_sum      <= calib_sum_next;
      calib_count    <= calib_count_next;
      unlock_strikes <= unlock_strikes_next;
      offset_tries   <= offset_tries_next;
    end
  end

  // item capture, window write, calibration mean and per-item results
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q   <= cmd;
      level_q <= fill_level;
    end
    if (ctl.push && !reset_pending && !cmd_q) begin
      avg_win[avg_idx] <= level_q;
    end
    calib_avg   <= calib_prod[RC_S +: 8];
    res_written <= res_written_next;
    res_err     <= res_err_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      freq_out     <= current_freq;
      freq_written <= res_written;
      locked       <= (mode == MODE_LOCKED);
      mode_out     <= mode;
      error_out    <= res_err;
    end
  end

endmodule

`default_nettype wire

// File: rtl/acdl_checker.sv
// port checker for the drift lock loop and its bind
`default_nettype none

`include "audio_clock_drift_lock_loop_unit_assert.svh"

module acdl_checker
  import acdl_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [15:0]          freq_out,
  input logic                 locked,
  input logic [1:0]           mode_out,
  input logic signed [11:0]   error_out
);

  // a stalled result holds its word and error
  `ACDL_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(freq_out) && $stable(error_out), "stalled result changed")

  // the word never leaves the PLL range
  `ACDL_ASSERT_IMP(a_word_range, out_valid, freq_out >= WORD_MIN && freq_out <= WORD_MAX, "word out of range")

  // lock flag agrees with the reported mode
  `ACDL_ASSERT_IMP(a_lock_mode, out_valid, locked == (mode_out == MODE_LOCKED), "lock flag and mode disagree")

  // a reported error lies outside the deadband and never ends in calibrate
  `ACDL_ASSERT_IMP(a_err_band, out_valid && error_out != 12'sd0, (error_out > 12'sd8 || error_out < -12'sd8) && mode_out != MODE_CALIB, "error inside deadband or in calibrate")

endmodule

bind audio_clock_drift_lock_loop_unit acdl_checker u_acdl_checker (.*);

`default_nettype wire
